// ===== hw/rtl/wxg_pkg.sv =====
// Shared types and constants for the write-xor-execute range guard.
`timescale 1ns / 1ps

package wxg_pkg;

    localparam int ADDR_W  = 64;
    localparam int SIZE_W  = 48;
    localparam int FLAGS_W = 32;
    localparam int CMD_W   = 2;
    localparam int CAUSE_W = 2;
    localparam int OUT_CNT_W = 6;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PROTECT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd2;

    // Deny causes.
    localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_WX_FLAG = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_PRIOR_W = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_OVERLAP = 2'd3;

    // Page protection bits.
    localparam logic [FLAGS_W-1:0] PROT_RW    = 32'h0000_0004;
    localparam logic [FLAGS_W-1:0] PROT_WC    = 32'h0000_0008;
    localparam logic [FLAGS_W-1:0] PROT_X     = 32'h0000_0010;
    localparam logic [FLAGS_W-1:0] PROT_XR    = 32'h0000_0020;
    localparam logic [FLAGS_W-1:0] PROT_XRW   = 32'h0000_0040;
    localparam logic [FLAGS_W-1:0] PROT_XWC   = 32'h0000_0080;
    localparam logic [FLAGS_W-1:0] PROT_WRITE = PROT_RW | PROT_WC | PROT_XRW | PROT_XWC;

    // What a request asks of the table as it walks the chain.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_CHECK,
        OP_INSERT,
        OP_FREE
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_HOLD
    } state_t;

    // Token handed from cell to cell.
    typedef struct packed {
        logic              active;
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] last;
        logic              ins_pending;
        logic              hit;
    } pkt_t;

endpackage

// ===== hw/rtl/wxg_cell.sv =====
// One table entry of the range guard with its stage of the request chain.
`timescale 1ns / 1ps

module wxg_cell #(
    parameter int CNT_W = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  wxg_pkg::pkt_t       pkt_in,
    input  logic [CNT_W-1:0]    rem_in,
    output wxg_pkg::pkt_t       pkt_out,
    output logic [CNT_W-1:0]    rem_out
);

    logic                       valid_reg, valid_next;
    logic [wxg_pkg::ADDR_W-1:0] base_reg, base_next;
    logic [wxg_pkg::ADDR_W-1:0] end_reg, end_next;
    wxg_pkg::pkt_t              pkt_reg, pkt_next;
    logic [CNT_W-1:0]           rem_reg, rem_next;

    logic hit_here;
    logic take_slot;
    logic drop;

    // Inclusive ends on both spans.
    assign hit_here = valid_reg &&
        ((pkt_in.addr >= base_reg && pkt_in.addr <= end_reg) ||
         (pkt_in.last >= base_reg && pkt_in.last <= end_reg) ||
         (pkt_in.addr <= base_reg && pkt_in.last >= end_reg));

    assign take_slot = pkt_in.active && (pkt_in.op == wxg_pkg::OP_INSERT) &&
                       pkt_in.ins_pending && !valid_reg;
    assign drop      = pkt_in.active && (pkt_in.op == wxg_pkg::OP_FREE) &&
                       valid_reg && (base_reg == pkt_in.addr);

    always_comb begin
        valid_next = valid_reg;
        base_next  = base_reg;
        end_next   = end_reg;
        if (take_slot) begin
            valid_next = 1'b1;
            base_next  = pkt_in.addr;
            end_next   = pkt_in.last;
        end else if (drop) begin
            valid_next = 1'b0;
        end
        pkt_next             = pkt_in;
        pkt_next.ins_pending = pkt_in.ins_pending & ~take_slot;
        pkt_next.hit         = pkt_in.hit |
                               (pkt_in.active && (pkt_in.op == wxg_pkg::OP_CHECK) && hit_here);
        rem_next             = rem_in + CNT_W'(drop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pkt_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            pkt_reg   <= pkt_next;
        end
        base_reg <= base_next;
        end_reg  <= end_next;
        rem_reg  <= rem_next;
    end

    assign pkt_out = pkt_reg;
    assign rem_out = rem_reg;

endmodule

// ===== hw/rtl/write_xor_execute_range_guard_unit.sv =====
// Top level of the write-xor-execute range guard: decode, cell chain and result stage.
`timescale 1ns / 1ps

// The guard keeps up to TABLE_DEPTH address ranges that were once writable and
// refuses to make them executable. Each request is decoded on acceptance, then
// a token walks a chain of TABLE_DEPTH cells, one cell per cycle; every cell
// holds one entry and checks overlap, claims itself for an insert (the lowest
// free cell wins) or invalidates itself on a matching free. After the last cell
// the result is held in the tail register until the output register is free;
// the block takes one request at a time, and s_tready rises again as soon as
// the result has moved into the output register, so a new request can be
// accepted while that result still waits for m_tready. The table needs no
// clearing pass after reset: only the per-cell valid bits are cleared.
module write_xor_execute_range_guard_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], address[65:2], size[113:66], protect_flags[145:114],
    // granted_addr[209:146], os_ok[210], prior_protect[242:211], zero fill above
    input  logic [247:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // denied[0], deny_cause[2:1], entry_added[3], table_full[4],
    // entries_removed[10:5], tracked_count[16:11], zero fill above
    output logic [23:0]  m_tdata
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Input fields.
    logic [wxg_pkg::CMD_W-1:0]   in_command;
    logic [wxg_pkg::ADDR_W-1:0]  in_address;
    logic [wxg_pkg::SIZE_W-1:0]  in_size;
    logic [wxg_pkg::FLAGS_W-1:0] in_flags;
    logic [wxg_pkg::ADDR_W-1:0]  in_granted;
    logic                        in_os_ok;
    logic [wxg_pkg::FLAGS_W-1:0] in_prior;

    assign in_command = s_tdata[1:0];
    assign in_address = s_tdata[65:2];
    assign in_size    = s_tdata[113:66];
    assign in_flags   = s_tdata[145:114];
    assign in_granted = s_tdata[209:146];
    assign in_os_ok   = s_tdata[210];
    assign in_prior   = s_tdata[242:211];

    wxg_pkg::state_t state_reg, state_next;

    logic accept;
    logic chain_done;
    logic tail_load;
    logic out_load;

    assign accept = s_tvalid && s_tready;

    // Request decode. Inserts only happen for flags without execute bits, so a
    // request never needs both the overlap check and an insert.
    logic                        dec_denied;
    logic [wxg_pkg::CAUSE_W-1:0] dec_cause;
    wxg_pkg::op_t                dec_op;
    logic [wxg_pkg::ADDR_W-1:0]  dec_base;
    logic                        flag_rw_only;
    logic                        flag_wc_only;

    assign flag_rw_only = (in_flags | wxg_pkg::PROT_RW) == wxg_pkg::PROT_RW;
    assign flag_wc_only = (in_flags | wxg_pkg::PROT_WC) == wxg_pkg::PROT_WC;

    always_comb begin
        dec_denied = 1'b0;
        dec_cause  = wxg_pkg::CAUSE_NONE;
        dec_op     = wxg_pkg::OP_NONE;
        dec_base   = in_address;
        case (in_command)
            wxg_pkg::CMD_ALLOC: begin
                dec_base = in_granted;
                if ((in_flags & (wxg_pkg::PROT_XRW | wxg_pkg::PROT_XWC)) != '0) begin
                    dec_denied = 1'b1;
                    dec_cause  = wxg_pkg::CAUSE_WX_FLAG;
                end else if (in_granted != '0 &&
                             (in_flags == wxg_pkg::PROT_RW || in_flags == wxg_pkg::PROT_WC)) begin
                    dec_op = wxg_pkg::OP_INSERT;
                end
            end
            wxg_pkg::CMD_PROTECT: begin
                if ((in_flags & wxg_pkg::PROT_XRW) != '0) begin
                    dec_denied = 1'b1;
                    dec_cause  = wxg_pkg::CAUSE_WX_FLAG;
                end else if ((in_flags & (wxg_pkg::PROT_X | wxg_pkg::PROT_XR)) != '0) begin
                    if ((in_prior & wxg_pkg::PROT_WRITE) != '0) begin
                        dec_denied = 1'b1;
                        dec_cause  = wxg_pkg::CAUSE_PRIOR_W;
                    end else begin
                        dec_op = wxg_pkg::OP_CHECK;
                    end
                end else if (in_os_ok && (flag_rw_only || flag_wc_only)) begin
                    dec_op = wxg_pkg::OP_INSERT;
                end
            end
            wxg_pkg::CMD_FREE: begin
                if (in_os_ok) begin
                    dec_op = wxg_pkg::OP_FREE;
                end
            end
            default: begin
                dec_op = wxg_pkg::OP_NONE;
            end
        endcase
    end

    // Launch register feeding the first cell; active for one cycle per request.
    wxg_pkg::pkt_t               launch_reg, launch_next;
    logic                        pre_denied_reg, pre_denied_next;
    logic [wxg_pkg::CAUSE_W-1:0] pre_cause_reg, pre_cause_next;

    always_comb begin
        launch_next        = launch_reg;
        launch_next.active = 1'b0;
        pre_denied_next    = pre_denied_reg;
        pre_cause_next     = pre_cause_reg;
        if (accept) begin
            launch_next.active      = 1'b1;
            launch_next.op          = dec_op;
            launch_next.addr        = dec_base;
            // End of the span wraps at 64 bits.
            launch_next.last        = dec_base + {{(wxg_pkg::ADDR_W - wxg_pkg::SIZE_W){1'b0}},
                                                  in_size};
            launch_next.ins_pending = 1'b1;
            launch_next.hit         = 1'b0;
            pre_denied_next         = dec_denied;
            pre_cause_next          = dec_cause;
        end
    end

    // Cell chain.
    wxg_pkg::pkt_t    pkt_chain [0:TABLE_DEPTH];
    logic [CNT_W-1:0] rem_chain [0:TABLE_DEPTH];

    assign pkt_chain[0] = launch_reg;
    assign rem_chain[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        wxg_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .pkt_in  (pkt_chain[g]),
            .rem_in  (rem_chain[g]),
            .pkt_out (pkt_chain[g+1]),
            .rem_out (rem_chain[g+1])
        );
    end

    assign chain_done = pkt_chain[TABLE_DEPTH].active;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wxg_pkg::ST_IDLE:  if (accept)     state_next = wxg_pkg::ST_SWEEP;
            wxg_pkg::ST_SWEEP: if (chain_done) state_next = wxg_pkg::ST_HOLD;
            wxg_pkg::ST_HOLD:  if (!m_tvalid || m_tready) state_next = wxg_pkg::ST_IDLE;
            default:           state_next = wxg_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready  = 1'b0;
        tail_load = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            wxg_pkg::ST_IDLE:  s_tready  = 1'b1;
            wxg_pkg::ST_SWEEP: tail_load = chain_done;
            wxg_pkg::ST_HOLD:  out_load  = !m_tvalid || m_tready;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // The token leaving the last cell is held until the output register is free.
    wxg_pkg::op_t     tail_op_reg, tail_op_next;
    logic             tail_pending_reg, tail_pending_next;
    logic             tail_hit_reg, tail_hit_next;
    logic [CNT_W-1:0] tail_rem_reg, tail_rem_next;

    always_comb begin
        tail_op_next      = tail_op_reg;
        tail_pending_next = tail_pending_reg;
        tail_hit_next     = tail_hit_reg;
        tail_rem_next     = tail_rem_reg;
        if (tail_load) begin
            tail_op_next      = pkt_chain[TABLE_DEPTH].op;
            tail_pending_next = pkt_chain[TABLE_DEPTH].ins_pending;
            tail_hit_next     = pkt_chain[TABLE_DEPTH].hit;
            tail_rem_next     = rem_chain[TABLE_DEPTH];
        end
    end

    // Result assembly and count update.
    logic                        res_denied;
    logic [wxg_pkg::CAUSE_W-1:0] res_cause;
    logic                        res_added;
    logic                        res_full;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [CNT_W-1:0]            cnt_after;
    logic [CNT_W+5:0]            rem_wide;
    logic [CNT_W+5:0]            cnt_wide;
    logic [wxg_pkg::OUT_CNT_W-1:0] res_removed;
    logic [wxg_pkg::OUT_CNT_W-1:0] res_tracked;

    always_comb begin
        res_denied = pre_denied_reg;
        res_cause  = pre_cause_reg;
        if (tail_op_reg == wxg_pkg::OP_CHECK && tail_hit_reg) begin
            res_denied = 1'b1;
            res_cause  = wxg_pkg::CAUSE_OVERLAP;
        end
        res_added   = (tail_op_reg == wxg_pkg::OP_INSERT) && !tail_pending_reg;
        res_full    = (tail_op_reg == wxg_pkg::OP_INSERT) && tail_pending_reg;
        cnt_after   = cnt_reg + CNT_W'(res_added) - tail_rem_reg;
        // Counts saturate at the width of the result fields.
        rem_wide    = (CNT_W + 6)'(tail_rem_reg);
        cnt_wide    = (CNT_W + 6)'(cnt_after);
        res_removed = (rem_wide > (CNT_W + 6)'(63)) ? 6'd63 : rem_wide[5:0];
        res_tracked = (cnt_wide > (CNT_W + 6)'(63)) ? 6'd63 : cnt_wide[5:0];
        cnt_next    = out_load ? cnt_after : cnt_reg;
    end

    // Output register.
    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg, m_tdata_next;

    always_comb begin
        m_tvalid_next = out_load | (m_tvalid_reg & ~m_tready);
        m_tdata_next  = m_tdata_reg;
        if (out_load) begin
            m_tdata_next = {7'd0, res_tracked, res_removed, res_full, res_added,
                            res_cause, res_denied};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wxg_pkg::ST_IDLE;
            launch_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            launch_reg   <= launch_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
        end
        pre_denied_reg   <= pre_denied_next;
        pre_cause_reg    <= pre_cause_next;
        tail_op_reg      <= tail_op_next;
        tail_pending_reg <= tail_pending_next;
        tail_hit_reg     <= tail_hit_next;
        tail_rem_reg     <= tail_rem_next;
        m_tdata_reg      <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hw/rtl/wxg_checker.sv =====
// Port-level checker for the range guard, bound to the top level.
`timescale 1ns / 1ps

module wxg_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [247:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [23:0]  m_tdata
);

    // A held result must not change while it waits.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request at a time: after an accepted request the input stays closed.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted during a sweep");

    // A cause is given exactly when the request is denied.
    a_cause_denied: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] != 2'd0)))
        else $error("deny cause does not match denied");

    // A denied request records nothing, and an insert is either done or dropped.
    a_no_add_on_deny: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[3]) && !(m_tdata[3] && m_tdata[4]))
        else $error("inconsistent insert flags");

    // Removals come only from a free, which never records a range and is never denied.
    a_removed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10:5] != 6'd0 |-> !m_tdata[3] && !m_tdata[0])
        else $error("removal reported with insert or deny");

endmodule

bind write_xor_execute_range_guard_unit wxg_checker u_wxg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
